### src/sbim_pkg.sv
// Shared types, codes and bit permutations for the scrambled bank mapper.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sbim_pkg;

	// Widths of the configuration port.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_CHR_PAGES   = 2'd0;
	localparam logic [1:0] REG_PRG_PAGES   = 2'd1;
	localparam logic [1:0] REG_FOUR_SCREEN = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [10:0] CHR_PAGES_RESET = 11'd0;
	localparam logic [8:0]  PRG_PAGES_RESET = 9'd2;

	// Kinds of input beat.
	localparam logic [1:0] OP_HIGH_WRITE = 2'd0;
	localparam logic [1:0] OP_LOW_WRITE  = 2'd1;
	localparam logic [1:0] OP_TICK       = 2'd2;

	// Kinds of bank update in a result.
	localparam logic [1:0] UPD_NONE     = 2'd0;
	localparam logic [1:0] UPD_CHR_PAIR = 2'd1;
	localparam logic [1:0] UPD_CHR_ONE  = 2'd2;
	localparam logic [1:0] UPD_PRG      = 2'd3;

	// High-range register decode.
	localparam logic [15:0] ADDR_MASK       = 16'hFF01;
	localparam logic [15:0] ADDR_SELECT     = 16'h8000;
	localparam logic [15:0] ADDR_SELECT_ALT = 16'h8800;
	localparam logic [15:0] ADDR_BANK       = 16'h8001;
	localparam logic [15:0] ADDR_BANK_ALT   = 16'h8801;
	localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
	localparam logic [15:0] ADDR_MIRROR_ALT = 16'hA800;
	localparam logic [15:0] ADDR_IRQ_CNT    = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_CNT_A  = 16'hC800;
	localparam logic [15:0] ADDR_IRQ_RLD    = 16'hC001;
	localparam logic [15:0] ADDR_IRQ_RLD_A  = 16'hC801;
	localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
	localparam logic [15:0] ADDR_IRQ_OFF_A  = 16'hE800;
	localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;
	localparam logic [15:0] ADDR_IRQ_ON_A   = 16'hE801;

	// Low-range scramble switch.
	localparam logic [15:0] SCRAMBLE_ADDR     = 16'h5000;
	localparam logic [7:0]  SCRAMBLE_ON_DATA  = 8'h02;
	localparam logic [7:0]  SCRAMBLE_OFF_DATA = 8'h00;

	// Bank data constants.
	localparam logic [7:0] PRG_SHORT_LIMIT = 8'h20;
	localparam logic [7:0] PAIR_MASK       = 8'hFE;
	localparam logic [2:0] SELECT_MASK     = 3'h7;
	localparam logic [2:0] LAST_CHR_SELECT = 3'd5;
	localparam logic [2:0] LAST_PAIR_SEL   = 3'd1;
	localparam logic [2:0] SINGLE_SLOT_OFS = 3'd2;

	// Scanline window in which ticks count.
	localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// Input beat.
	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [8:0]  scanline;
		logic        rendering_on;
	} in_item_t;

	// Result beat.
	typedef struct packed {
		logic [1:0]  bank_update;
		logic [2:0]  bank_slot;
		logic [10:0] bank_page;
		logic        mirror_update;
		logic        mirror_horizontal;
		logic        irq_pending;
	} out_item_t;

	// Configuration register contents.
	typedef struct packed {
		logic [10:0] chr_page_count;
		logic [8:0]  prg_page_count;
		logic        four_screen;
	} cfg_t;

	// Request to the remainder unit.
	typedef struct packed {
		logic        start;
		logic [7:0]  dividend;
		logic [10:0] divisor;
	} rem_req_t;

	// Response from the remainder unit.
	typedef struct packed {
		logic       done;
		logic [7:0] remainder;
	} rem_rsp_t;

	// Eight-bit scramble used for pattern data and high program data.
	function automatic logic [7:0] perm_long(input logic [7:0] d);
		perm_long = {d[5], d[4], d[2], d[6], d[7], d[3], d[1], d[0]};
	endfunction

	// Five-bit scramble used for low program data.
	function automatic logic [4:0] perm_short(input logic [4:0] d);
		perm_short = {d[2], d[1], d[3], d[4], d[0]};
	endfunction

endpackage

### src/sbim_rem_unit.sv
// Restoring remainder unit: eight-bit dividend by an eleven-bit divisor,
// one quotient bit per cycle. Depends on sbim_pkg.
`timescale 1ns / 1ps

module sbim_rem_unit
	import sbim_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [2:0]  step_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvd_q;
	logic [10:0] div_q;
	logic [8:0]  trial;
	logic        fits;
	logic [7:0]  rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	// The partial remainder stays below 256 for any divisor.
	always_comb begin
		trial    = {rem_q, dvd_q[7]};
		fits     = {2'b00, trial} >= div_q;
		rem_next = fits ? 8'(({2'b00, trial} - div_q)) : trial[7:0];
	end

	// Control: busy for eight steps, done pulses after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[6:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

### src/sbim_apb_regs.sv
// Configuration register file behind an APB-style port.
// Depends on sbim_pkg.
`timescale 1ns / 1ps

module sbim_apb_regs
	import sbim_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chr_page_count <= CHR_PAGES_RESET;
			cfg_q.prg_page_count <= PRG_PAGES_RESET;
			cfg_q.four_screen    <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CHR_PAGES:   cfg_q.chr_page_count <= pwdata[10:0];
				REG_PRG_PAGES:   cfg_q.prg_page_count <= pwdata[8:0];
				REG_FOUR_SCREEN: cfg_q.four_screen    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			REG_CHR_PAGES:   prdata = {21'd0, cfg_q.chr_page_count};
			REG_PRG_PAGES:   prdata = {23'd0, cfg_q.prg_page_count};
			REG_FOUR_SCREEN: prdata = {31'd0, cfg_q.four_screen};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### src/scrambled_bank_switch_irq_mapper.sv
// Top level of the scrambled bank mapper: sequencer, mapper state and result register.
// Depends on sbim_pkg, sbim_rem_unit and sbim_apb_regs.
`timescale 1ns / 1ps

// Usage:
// Input beats (in_valid / in_stall / in_data) carry CPU writes and scanline
// ticks; every accepted beat gives exactly one result beat on out_valid /
// out_stall / out_data, in order. Configuration registers sit on the APB-style
// port at byte addresses 0, 4 and 8; the user must write them only while the
// block is idle, as the block itself does not enforce it.
// The block works on one beat at a time and holds in_stall high until it is
// done. A bank-data write with a nonzero page count goes through the shared
// eight-step remainder unit, one quotient bit per cycle: the beat is decoded,
// the unit runs its steps and the result enters the output register when free.
// Every other beat is decoded and enters the output register when it is free.
// The result register lets a new beat be accepted while the previous result
// still waits; if the receiver keeps out_stall high, the finished result of
// the next beat waits inside and in_stall stays high.
// Reset clears the mapper state, sets the page counts to 0 and 2 and empties
// the output register.

module scrambled_bank_switch_irq_mapper
	import sbim_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t      cfg;
	rem_req_t  rem_req;
	rem_rsp_t  rem_rsp;

	state_t    state_q, state_d;
	in_item_t  item_q;
	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic      pair_q;

	logic [2:0] bank_select_q;
	logic       scramble_on_q;
	logic       irq_enabled_q;
	logic [7:0] irq_count_q;
	logic [7:0] irq_reload_q;
	logic       irq_raised_q;

	// Decode results for the beat held in item_q.
	logic [2:0]  dec_bank_select;
	logic        dec_scramble;
	logic        dec_irq_enabled;
	logic [7:0]  dec_irq_count;
	logic [7:0]  dec_irq_reload;
	logic        dec_irq_raised;
	out_item_t   dec_res;
	logic        dec_div;
	logic        dec_pair;
	logic [7:0]  dec_dividend;
	logic [10:0] dec_divisor;

	logic        accept_in;
	logic        out_free;
	logic        load_out;

	sbim_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbim_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Decode of one beat against the current mapper state.
	always_comb begin
		logic [15:0] masked;
		logic [7:0]  d;
		logic [7:0]  d_chr;
		logic [7:0]  d_prg;
		logic [7:0]  cnt;
		masked = item_q.address & ADDR_MASK;
		d      = item_q.write_data;
		d_chr  = scramble_on_q ? perm_long(d) : d;
		if (!scramble_on_q) begin
			d_prg = d;
		end else if (d < PRG_SHORT_LIMIT) begin
			d_prg = {3'b000, perm_short(d[4:0])};
		end else begin
			d_prg = perm_long(d - PRG_SHORT_LIMIT);
		end
		cnt = irq_count_q;

		dec_bank_select = bank_select_q;
		dec_scramble    = scramble_on_q;
		dec_irq_enabled = irq_enabled_q;
		dec_irq_count   = irq_count_q;
		dec_irq_reload  = irq_reload_q;
		dec_irq_raised  = irq_raised_q;
		dec_res         = '0;
		dec_div         = 1'b0;
		dec_pair        = 1'b0;
		dec_dividend    = '0;
		dec_divisor     = '0;

		case (item_q.operation)
			OP_HIGH_WRITE: begin
				case (masked)
					ADDR_SELECT, ADDR_SELECT_ALT: begin
						dec_bank_select = d[2:0] & SELECT_MASK;
					end
					ADDR_BANK, ADDR_BANK_ALT: begin
						if (bank_select_q <= LAST_CHR_SELECT) begin
							// Pattern page, reduced by the pattern page count.
							if (cfg.chr_page_count != '0) begin
								dec_div     = 1'b1;
								dec_divisor = cfg.chr_page_count;
								if (bank_select_q <= LAST_PAIR_SEL) begin
									dec_pair                = 1'b1;
									dec_res.bank_update     = UPD_CHR_PAIR;
									dec_res.bank_slot       = {bank_select_q[1:0], 1'b0};
									dec_dividend            = d_chr & PAIR_MASK;
								end else begin
									dec_res.bank_update     = UPD_CHR_ONE;
									dec_res.bank_slot       = bank_select_q + SINGLE_SLOT_OFS;
									dec_dividend            = d_chr;
								end
							end
						end else if (cfg.prg_page_count != '0) begin
							// Program page, reduced by the program page count.
							dec_div             = 1'b1;
							dec_divisor         = {2'b00, cfg.prg_page_count};
							dec_dividend        = d_prg;
							dec_res.bank_update = UPD_PRG;
							dec_res.bank_slot   = {2'b00, bank_select_q[0]};
						end
					end
					ADDR_MIRROR, ADDR_MIRROR_ALT: begin
						if (!cfg.four_screen) begin
							dec_res.mirror_update     = 1'b1;
							dec_res.mirror_horizontal = d[0];
						end
					end
					ADDR_IRQ_CNT, ADDR_IRQ_CNT_A: begin
						dec_irq_count  = d;
						dec_irq_raised = 1'b0;
					end
					ADDR_IRQ_RLD, ADDR_IRQ_RLD_A: begin
						dec_irq_reload = d;
						dec_irq_raised = 1'b0;
					end
					ADDR_IRQ_OFF, ADDR_IRQ_OFF_A: begin
						dec_irq_enabled = 1'b0;
						dec_irq_raised  = 1'b0;
					end
					ADDR_IRQ_ON, ADDR_IRQ_ON_A: begin
						dec_irq_enabled = 1'b1;
						dec_irq_raised  = 1'b0;
					end
					default: ;
				endcase
			end
			OP_LOW_WRITE: begin
				if (item_q.address == SCRAMBLE_ADDR) begin
					if (d == SCRAMBLE_OFF_DATA) begin
						dec_scramble = 1'b0;
					end else if (d == SCRAMBLE_ON_DATA) begin
						dec_scramble = 1'b1;
					end
				end
			end
			OP_TICK: begin
				// Scanline counter; scanline 0 takes an extra decrement first.
				if (item_q.scanline <= LAST_VISIBLE_LINE && item_q.rendering_on &&
					irq_enabled_q && !irq_raised_q) begin
					if (item_q.scanline == '0 && cnt != '0) begin
						cnt = cnt - 8'd1;
					end
					if (cnt == '0) begin
						dec_irq_raised = 1'b1;
						dec_irq_count  = irq_reload_q;
					end else begin
						dec_irq_count  = cnt - 8'd1;
					end
				end
			end
			default: ;
		endcase

		dec_res.irq_pending = dec_irq_raised;
	end

	// Sequencer: next state and handshake controls.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_free = !out_valid_q || !out_stall;
		load_out = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = dec_dividend;
		rem_req.divisor  = dec_divisor;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (dec_div) begin
					rem_req.start = 1'b1;
					state_d       = ST_DIVIDE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIVIDE: begin
				if (rem_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept_in = in_valid && !in_stall;

	// State register and mapper state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			bank_select_q <= '0;
			scramble_on_q <= 1'b0;
			irq_enabled_q <= 1'b0;
			irq_count_q   <= '0;
			irq_reload_q  <= '0;
			irq_raised_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DECODE) begin
				bank_select_q <= dec_bank_select;
				scramble_on_q <= dec_scramble;
				irq_enabled_q <= dec_irq_enabled;
				irq_count_q   <= dec_irq_count;
				irq_reload_q  <= dec_irq_reload;
				irq_raised_q  <= dec_irq_raised;
			end
		end
	end

	// Beat capture, result assembly and output register.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_q <= in_data;
		end
		if (state_q == ST_DECODE) begin
			res_q  <= dec_res;
			pair_q <= dec_pair;
		end
		if (state_q == ST_DIVIDE && rem_rsp.done) begin
			res_q.bank_page <= {3'b000, pair_q ? (rem_rsp.remainder & PAIR_MASK)
			                                   : rem_rsp.remainder};
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/sbim_checker.sv
// Port-level checks for the scrambled bank mapper, bound to its top level.
// Depends on sbim_pkg and scrambled_bank_switch_irq_mapper.
`timescale 1ns / 1ps

module sbim_checker
	import sbim_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// One beat at a time: the block is busy right after it takes a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a beat was still in work");

	// A new result only shows up while the block was busy with a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat appeared without a beat in work");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed or vanished");

	// Pair updates land on an even page in slot 0 or 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bank_update == UPD_CHR_PAIR |->
		!out_data.bank_page[0] && (out_data.bank_slot == 3'd0 || out_data.bank_slot == 3'd2))
		else $error("pattern pair update with odd page or bad slot");

	// Program updates use slot 0 or 1 only.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bank_update == UPD_PRG |-> out_data.bank_slot[2:1] == 2'b00)
		else $error("program update with a slot above 1");

endmodule

bind scrambled_bank_switch_irq_mapper sbim_checker u_sbim_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### sim/scrambled_bank_switch_irq_mapper_test.sv
// Self-checking regression for the scrambled bank mapper: directed beats, random traffic,
// back-pressure and several register settings, checked against an in-bench predictor.
// Depends on sbim_pkg and scrambled_bank_switch_irq_mapper.
`timescale 1ns / 1ps

module scrambled_bank_switch_irq_mapper_test;
	import sbim_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 30;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] FIRST_PRG_SELECT = 3'd6;
	localparam logic [8:0] LINES_PER_FRAME = 9'd262;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Predictor copy of the configuration and of the mapper state.
	logic [10:0] cfg_chr = CHR_PAGES_RESET;
	logic [8:0]  cfg_prg = PRG_PAGES_RESET;
	logic        cfg_four = 1'b0;
	logic [2:0]  sel_q = 3'd0;
	logic        scramble_q = 1'b0;
	logic        irq_en_q = 1'b0;
	logic [7:0]  irq_cnt_q = 8'd0;
	logic [7:0]  irq_latch_q = 8'd0;
	logic        irq_flag_q = 1'b0;

	out_item_t pending_results[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	bit        sender_gaps_on = 1'b1;
	bit        hold_request = 1'b0;

	scrambled_bank_switch_irq_mapper i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("scrambled_bank_switch_irq_mapper regression: fail");
		$finish;
	end

	// Bit scrambles of the bank data.
	function automatic logic [7:0] scramble8(logic [7:0] d);
		return {d[5], d[4], d[2], d[6], d[7], d[3], d[1], d[0]};
	endfunction

	function automatic logic [4:0] scramble5(logic [4:0] d);
		return {d[2], d[1], d[3], d[4], d[0]};
	endfunction

	// Advances the predictor by one input beat and returns the result it should give.
	function automatic out_item_t map_item(in_item_t it);
		out_item_t   r;
		logic [7:0]  d;
		logic [15:0] key;
		int unsigned pg;
		r = '0;
		d = it.write_data;
		key = it.address & ADDR_MASK;
		case (it.operation)
			OP_HIGH_WRITE: begin
				if (key == ADDR_SELECT || key == ADDR_SELECT_ALT) begin
					sel_q = d[2:0] & SELECT_MASK;
				end else if (key == ADDR_BANK || key == ADDR_BANK_ALT) begin
					if (sel_q <= LAST_CHR_SELECT) begin
						if (scramble_q)
							d = scramble8(d);
						if (cfg_chr != 0) begin
							if (sel_q <= LAST_PAIR_SEL) begin
								pg = (int'(d & PAIR_MASK) % int'(cfg_chr)) & 'h7FE;
								r.bank_update = UPD_CHR_PAIR;
								r.bank_slot = sel_q * 3'd2;
							end else begin
								pg = int'(d) % int'(cfg_chr);
								r.bank_update = UPD_CHR_ONE;
								r.bank_slot = sel_q + SINGLE_SLOT_OFS;
							end
							r.bank_page = pg[10:0];
						end
					end else begin
						if (scramble_q) begin
							if (d < PRG_SHORT_LIMIT)
								d = {3'b000, scramble5(d[4:0])};
							else
								d = scramble8(d - PRG_SHORT_LIMIT);
						end
						if (cfg_prg != 0) begin
							pg = int'(d) % int'(cfg_prg);
							r.bank_update = UPD_PRG;
							r.bank_slot = sel_q - FIRST_PRG_SELECT;
							r.bank_page = pg[10:0];
						end
					end
				end else if (key == ADDR_MIRROR || key == ADDR_MIRROR_ALT) begin
					if (!cfg_four) begin
						r.mirror_update = 1'b1;
						r.mirror_horizontal = d[0];
					end
				end else if (key == ADDR_IRQ_CNT || key == ADDR_IRQ_CNT_A) begin
					irq_cnt_q = d;
					irq_flag_q = 1'b0;
				end else if (key == ADDR_IRQ_RLD || key == ADDR_IRQ_RLD_A) begin
					irq_latch_q = d;
					irq_flag_q = 1'b0;
				end else if (key == ADDR_IRQ_OFF || key == ADDR_IRQ_OFF_A) begin
					irq_en_q = 1'b0;
					irq_flag_q = 1'b0;
				end else if (key == ADDR_IRQ_ON || key == ADDR_IRQ_ON_A) begin
					irq_en_q = 1'b1;
					irq_flag_q = 1'b0;
				end
			end
			OP_LOW_WRITE: begin
				if (it.address == SCRAMBLE_ADDR) begin
					if (d == SCRAMBLE_OFF_DATA)
						scramble_q = 1'b0;
					else if (d == SCRAMBLE_ON_DATA)
						scramble_q = 1'b1;
				end
			end
			OP_TICK: begin
				// Only visible lines with rendering on count, and only while no IRQ waits.
				if (it.scanline <= LAST_VISIBLE_LINE && it.rendering_on && irq_en_q &&
						!irq_flag_q) begin
					if (it.scanline == 0 && irq_cnt_q != 0)
						irq_cnt_q--;
					if (irq_cnt_q == 0) begin
						irq_flag_q = 1'b1;
						irq_cnt_q = irq_latch_q;
					end else begin
						irq_cnt_q--;
					end
				end
			end
			default: begin
			end
		endcase
		r.irq_pending = irq_flag_q;
		return r;
	endfunction

	// Beat builders; fields that the block ignores carry random values.
	function automatic in_item_t hi_write(logic [15:0] base, logic [7:0] data);
		in_item_t it;
		it.operation = OP_HIGH_WRITE;
		it.address = base | (16'($urandom) & 16'h00FE);
		it.write_data = data;
		it.scanline = 9'($urandom_range(0, 261));
		it.rendering_on = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t lo_write(logic [15:0] addr, logic [7:0] data);
		in_item_t it;
		it.operation = OP_LOW_WRITE;
		it.address = addr;
		it.write_data = data;
		it.scanline = 9'($urandom_range(0, 261));
		it.rendering_on = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t tick(logic [8:0] line, logic rend);
		in_item_t it;
		it.operation = OP_TICK;
		it.address = 16'($urandom);
		it.write_data = 8'($urandom);
		it.scanline = line;
		it.rendering_on = rend;
		return it;
	endfunction

	function automatic logic [15:0] pick(logic [15:0] base, logic [15:0] alt);
		return $urandom_range(0, 1) ? alt : base;
	endfunction

	// Offers one beat, holds it until accepted and records the predicted result.
	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(map_item(it));
	endtask

	// Sender bursts: after a burst of random length, valid drops for a random gap.
	task automatic pace();
		int gap;
		if (sender_gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle.
	task automatic cfg_write(logic [1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (index)
			REG_CHR_PAGES:   cfg_chr = value[10:0];
			REG_PRG_PAGES:   cfg_prg = value[8:0];
			REG_FOUR_SCREEN: cfg_four = value[0];
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers change only once every result is back.
	task automatic apply_config(int chr, int prg, bit four);
		stop_sending();
		wait_drained();
		cfg_write(REG_CHR_PAGES, chr);
		cfg_write(REG_PRG_PAGES, prg);
		cfg_write(REG_FOUR_SCREEN, four);
	endtask

	// Reset page counts: pattern RAM, two program pages, mirroring writable.
	task automatic test_reset_defaults();
		send_item(hi_write(ADDR_SELECT, 8'hF8));
		send_item(hi_write(ADDR_BANK, 8'hFF));
		send_item(hi_write(ADDR_SELECT_ALT, 8'h06));
		send_item(hi_write(ADDR_BANK_ALT, 8'hFF));
		send_item(hi_write(ADDR_MIRROR, 8'h01));
		send_item(hi_write(ADDR_MIRROR | 16'h0001, 8'hFF));
		send_item('{operation: OP_UNUSED, address: 16'hFFFF, write_data: 8'hFF,
			scanline: 9'd261, rendering_on: 1'b1});
		send_item(lo_write(SCRAMBLE_ADDR, SCRAMBLE_ON_DATA));
		// Program data on both sides of the short-scramble limit.
		send_item(hi_write(ADDR_SELECT, 8'h07));
		send_item(hi_write(ADDR_BANK, 8'h1F));
		send_item(hi_write(ADDR_BANK, 8'h20));
	endtask

	// Odd pattern count, no program pages and a fixed four-screen layout.
	task automatic test_odd_pages_four_screen();
		apply_config(5, 0, 1'b1);
		send_item(hi_write(ADDR_SELECT, 8'h01));
		send_item(hi_write(ADDR_BANK, 8'hFF));
		send_item(hi_write(ADDR_SELECT, 8'h06));
		send_item(hi_write(ADDR_BANK, 8'h33));
		send_item(hi_write(ADDR_MIRROR_ALT, 8'h01));
		send_item(lo_write(SCRAMBLE_ADDR, 8'h03));
		send_item(lo_write(SCRAMBLE_ADDR, SCRAMBLE_OFF_DATA));
	endtask

	// Counter reload, the extra decrement on line zero, and the counting window.
	task automatic test_irq_counter();
		send_item(hi_write(ADDR_IRQ_RLD, 8'h02));
		send_item(hi_write(ADDR_IRQ_CNT, 8'h00));
		send_item(hi_write(ADDR_IRQ_ON, 8'h00));
		send_item(tick(9'd0, 1'b1));
		send_item(tick(9'd10, 1'b1));
		send_item(hi_write(ADDR_IRQ_ON_A, 8'h00));
		send_item(tick(9'd0, 1'b1));
		send_item(tick(9'd1, 1'b1));
		send_item(tick(9'd240, 1'b1));
		send_item(tick(9'd2, 1'b0));
		send_item(hi_write(ADDR_IRQ_OFF, 8'h00));
	endtask

	// Mostly well-formed traffic: select/data pairs, IRQ setup and frames of ticks.
	task automatic test_random_traffic(int count);
		int sent;
		int choice;
		int len;
		logic [8:0] line;
		logic [15:0] base;
		sent = 0;
		while (sent < count) begin
			choice = $urandom_range(0, 99);
			if (choice < 30) begin
				send_item(hi_write(pick(ADDR_SELECT, ADDR_SELECT_ALT), 8'($urandom)));
				pace();
				send_item(hi_write(pick(ADDR_BANK, ADDR_BANK_ALT), 8'($urandom)));
				pace();
				sent += 2;
			end else if (choice < 40) begin
				send_item(hi_write(pick(ADDR_MIRROR, ADDR_MIRROR_ALT), 8'($urandom)));
				pace();
				sent++;
			end else if (choice < 52) begin
				case ($urandom_range(0, 3))
					0: base = pick(ADDR_IRQ_CNT, ADDR_IRQ_CNT_A);
					1: base = pick(ADDR_IRQ_RLD, ADDR_IRQ_RLD_A);
					2: base = pick(ADDR_IRQ_OFF, ADDR_IRQ_OFF_A);
					default: base = pick(ADDR_IRQ_ON, ADDR_IRQ_ON_A);
				endcase
				send_item(hi_write(base, $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) :
					8'($urandom)));
				pace();
				sent++;
			end else if (choice < 80) begin
				// A stretch of scanlines, often after arming the counter.
				if ($urandom_range(0, 1)) begin
					send_item(hi_write(ADDR_IRQ_RLD, 8'($urandom_range(0, 6))));
					pace();
					send_item(hi_write(ADDR_IRQ_ON, 8'($urandom)));
					pace();
					sent += 2;
				end
				line = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(0, 261));
				len = $urandom_range(1, 24);
				repeat (len) begin
					send_item(tick(line, $urandom_range(0, 9) != 0));
					pace();
					line = (line + 9'd1 == LINES_PER_FRAME) ? 9'd0 : line + 9'd1;
				end
				sent += len;
			end else if (choice < 86) begin
				case ($urandom_range(0, 3))
					0: send_item(lo_write(SCRAMBLE_ADDR, SCRAMBLE_OFF_DATA));
					1: send_item(lo_write(SCRAMBLE_ADDR, SCRAMBLE_ON_DATA));
					2: send_item(lo_write(SCRAMBLE_ADDR, 8'($urandom)));
					default: send_item(lo_write(16'($urandom), SCRAMBLE_ON_DATA));
				endcase
				pace();
				sent++;
			end else begin
				// Noise: any operation at any address; not counted.
				send_item('{operation: 2'($urandom), address: 16'($urandom),
					write_data: 8'($urandom), scanline: 9'($urandom_range(0, 511)),
					rendering_on: 1'($urandom)});
				pace();
			end
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering beats.
	task automatic test_backpressure();
		sender_gaps_on = 1'b0;
		hold_request = 1'b1;
		test_random_traffic(30);
		sender_gaps_on = 1'b1;
	endtask

	// Sender pauses until every result is back, then resumes.
	task automatic test_drain_pause();
		test_random_traffic(12);
		stop_sending();
		wait_drained();
		test_random_traffic(12);
	endtask

	// Receiver: out_stall follows a randomly chosen pattern, picked anew when its run ends.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		int          phase;
		out_stall = 1'b0;
		mode = STALL_NONE;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 4) < 3);
					default:     out_stall <= (phase % 3 == 0);
				endcase
			end
		end
	end

	task automatic report(string what, out_item_t want, out_item_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%s: expected upd=%0d slot=%0d page=%0d mir=%b hor=%b irq=%b",
				what, want.bank_update, want.bank_slot, want.bank_page,
				want.mirror_update, want.mirror_horizontal, want.irq_pending);
			$display("%s: got      upd=%0d slot=%0d page=%0d mir=%b hor=%b irq=%b",
				what, got.bank_update, got.bank_slot, got.bank_page,
				got.mirror_update, got.mirror_horizontal, got.irq_pending);
		end
	endtask

	// Every accepted result beat is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("result beat with none due", '0, out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data.bank_update !== want.bank_update ||
						out_data.bank_slot !== want.bank_slot ||
						out_data.bank_page !== want.bank_page ||
						out_data.mirror_update !== want.mirror_update ||
						out_data.mirror_horizontal !== want.mirror_horizontal ||
						out_data.irq_pending !== want.irq_pending)
					report("result mismatch", want, out_data);
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_odd_pages_four_screen();
		test_irq_counter();

		apply_config(2040, 510, 1'b0);
		test_random_traffic(100);
		test_backpressure();
		apply_config(1, 2, 1'b1);
		test_random_traffic(60);
		apply_config(0, 3, 1'b0);
		test_random_traffic(60);
		test_drain_pause();
		apply_config(7, 255, 1'b1);
		test_random_traffic(60);
		apply_config($urandom_range(1, 2040), $urandom_range(2, 510), 1'($urandom));
		test_random_traffic(60);

		stop_sending();
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("scrambled_bank_switch_irq_mapper regression: pass");
		else
			$display("scrambled_bank_switch_irq_mapper regression: fail");
		$finish;
	end

endmodule

### sim.f
src/sbim_pkg.sv
src/sbim_rem_unit.sv
src/sbim_apb_regs.sv
src/scrambled_bank_switch_irq_mapper.sv
src/sbim_checker.sv
sim/scrambled_bank_switch_irq_mapper_test.sv
